// ===== rtl/qvr_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, payload types and status types for the quaternion vector rotator.
// No dependencies; every other file imports this package.
package qvr_pkg;

    localparam int QUAT_W    = 16;
    localparam int VEC_W     = 16;
    localparam int OUT_W     = 18;
    localparam int FRAC_W    = 2 * (QUAT_W - 1);
    localparam int PROD_W    = 2 * QUAT_W;
    localparam int MAT_W     = PROD_W + 2;
    localparam int MUL_W     = MAT_W + VEC_W;
    localparam int ACC_W     = MUL_W + 2;
    localparam int SHR_W     = ACC_W - FRAC_W;
    localparam int S_TDATA_W = ((4 * QUAT_W + 3 * VEC_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] z;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] x;
    } vec_t;

    // Rotation matrix, row-major, entries scaled by 2^FRAC_W.
    typedef struct packed {
        logic signed [MAT_W-1:0] m8;
        logic signed [MAT_W-1:0] m7;
        logic signed [MAT_W-1:0] m6;
        logic signed [MAT_W-1:0] m5;
        logic signed [MAT_W-1:0] m4;
        logic signed [MAT_W-1:0] m3;
        logic signed [MAT_W-1:0] m2;
        logic signed [MAT_W-1:0] m1;
        logic signed [MAT_W-1:0] m0;
    } mat_t;

    // Occupancy of the matrix pipeline stages.
    typedef struct packed {
        logic s1_vld;
        logic s2_vld;
    } qvr_stat_t;

endpackage

// ===== rtl/qvr_matrix.sv =====
`timescale 1ns / 1ps
// Two pipeline stages that turn a quaternion into its rotation matrix.
// Depends on qvr_pkg; the vector rides along so that it stays aligned with the matrix.
module qvr_matrix
    import qvr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_vld,
    output logic      in_rdy,
    input  quat_t     in_quat,
    input  vec_t      in_vec,
    output logic      out_vld,
    input  logic      out_rdy,
    output mat_t      out_mat,
    output vec_t      out_vec,
    output qvr_stat_t stat
);

    logic s1_vld_reg;
    logic s2_vld_reg;
    logic s1_rdy;
    logic s2_rdy;

    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [PROD_W-1:0] ww_next, xx_next, yy_next, zz_next;
    logic signed [PROD_W-1:0] xy_next, wz_next, xz_next, wy_next, yz_next, wx_next;
    vec_t s1_vec_reg;
    vec_t s2_vec_reg;
    mat_t mat_reg;
    mat_t mat_next;

    assign s2_rdy = !s2_vld_reg || out_rdy;
    assign s1_rdy = !s1_vld_reg || s2_rdy;
    assign in_rdy = s1_rdy;

    // Stage one: the ten distinct products of quaternion parts.
    always_comb
    begin
        ww_next = in_quat.w * in_quat.w;
        xx_next = in_quat.x * in_quat.x;
        yy_next = in_quat.y * in_quat.y;
        zz_next = in_quat.z * in_quat.z;
        xy_next = in_quat.x * in_quat.y;
        wz_next = in_quat.w * in_quat.z;
        xz_next = in_quat.x * in_quat.z;
        wy_next = in_quat.w * in_quat.y;
        yz_next = in_quat.y * in_quat.z;
        wx_next = in_quat.w * in_quat.x;
    end

    // Stage two: sums, differences and doubled sums and differences that form the matrix entries.
    always_comb
    begin
        mat_next.m0 = MAT_W'(ww_reg) + MAT_W'(xx_reg) - MAT_W'(yy_reg) - MAT_W'(zz_reg);
        mat_next.m1 = (MAT_W'(xy_reg) - MAT_W'(wz_reg)) <<< 1;
        mat_next.m2 = (MAT_W'(xz_reg) + MAT_W'(wy_reg)) <<< 1;
        mat_next.m3 = (MAT_W'(xy_reg) + MAT_W'(wz_reg)) <<< 1;
        mat_next.m4 = MAT_W'(ww_reg) - MAT_W'(xx_reg) + MAT_W'(yy_reg) - MAT_W'(zz_reg);
        mat_next.m5 = (MAT_W'(yz_reg) - MAT_W'(wx_reg)) <<< 1;
        mat_next.m6 = (MAT_W'(xz_reg) - MAT_W'(wy_reg)) <<< 1;
        mat_next.m7 = (MAT_W'(yz_reg) + MAT_W'(wx_reg)) <<< 1;
        mat_next.m8 = MAT_W'(ww_reg) - MAT_W'(xx_reg) - MAT_W'(yy_reg) + MAT_W'(zz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_vld_reg <= in_vld;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_vld)
        begin
            ww_reg     <= ww_next;
            xx_reg     <= xx_next;
            yy_reg     <= yy_next;
            zz_reg     <= zz_next;
            xy_reg     <= xy_next;
            wz_reg     <= wz_next;
            xz_reg     <= xz_next;
            wy_reg     <= wy_next;
            yz_reg     <= yz_next;
            wx_reg     <= wx_next;
            s1_vec_reg <= in_vec;
        end
        if (s2_rdy && s1_vld_reg)
        begin
            mat_reg    <= mat_next;
            s2_vec_reg <= s1_vec_reg;
        end
    end

    assign out_vld     = s2_vld_reg;
    assign out_mat     = mat_reg;
    assign out_vec     = s2_vec_reg;
    assign stat.s1_vld = s1_vld_reg;
    assign stat.s2_vld = s2_vld_reg;

endmodule

// ===== rtl/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// An accepted input word passes through registered stages one to five to the master side.
// Throughput: one word per cycle while m_tready stays high, as every stage registers its word.
// Each stage holds its word while stalled and fills bubbles ahead of it independently.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits and the in-flight count.
// Depends on qvr_pkg and qvr_matrix.
module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, low bit up: quat_w, quat_x, quat_y, quat_z, in_x, in_y, in_z
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, low bit up: out_x, out_y, out_z, zero padding to a whole byte
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: saturated
    output logic                 m_tuser
);

    // The fixed-point result is floor((sum + half LSB) / 2^FRAC_W); the half LSB is
    // folded into the stage-four adder so that stage five is a plain arithmetic shift.
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [SHR_W-1:0] SAT_HI     = SHR_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SHR_W-1:0] SAT_LO     = -SAT_HI - SHR_W'(1);
    localparam logic signed [OUT_W-1:0] OUT_HI     = OUT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [OUT_W-1:0] OUT_LO     = -OUT_HI - OUT_W'(1);

    // Unpack the incoming word.
    quat_t     in_quat;
    vec_t      in_vec;
    logic      mat_vld;
    logic      mat_rdy;
    mat_t      mat;
    vec_t      mat_vec;
    qvr_stat_t mat_stat;

    assign in_quat.w = s_tdata[0 * QUAT_W +: QUAT_W];
    assign in_quat.x = s_tdata[1 * QUAT_W +: QUAT_W];
    assign in_quat.y = s_tdata[2 * QUAT_W +: QUAT_W];
    assign in_quat.z = s_tdata[3 * QUAT_W +: QUAT_W];
    assign in_vec.x  = s_tdata[4 * QUAT_W + 0 * VEC_W +: VEC_W];
    assign in_vec.y  = s_tdata[4 * QUAT_W + 1 * VEC_W +: VEC_W];
    assign in_vec.z  = s_tdata[4 * QUAT_W + 2 * VEC_W +: VEC_W];

    // Stages one and two build the rotation matrix.
    qvr_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s_tvalid),
        .in_rdy  (s_tready),
        .in_quat (in_quat),
        .in_vec  (in_vec),
        .out_vld (mat_vld),
        .out_rdy (mat_rdy),
        .out_mat (mat),
        .out_vec (mat_vec),
        .stat    (mat_stat)
    );

    logic s3_vld_reg;
    logic s4_vld_reg;
    logic s5_vld_reg;
    logic s3_rdy;
    logic s4_rdy;
    logic s5_rdy;

    logic signed [MUL_W-1:0] prod_reg  [9];
    logic signed [MUL_W-1:0] prod_next [9];
    logic signed [ACC_W-1:0] acc_reg   [3];
    logic signed [ACC_W-1:0] acc_next  [3];
    logic signed [SHR_W-1:0] shr       [3];
    logic signed [OUT_W-1:0] res_next  [3];
    logic signed [OUT_W-1:0] res_reg   [3];
    logic                    sat_next;
    logic                    sat_reg;

    // Each stage takes a new word when it is empty or its own word moves on this cycle.
    assign s5_rdy  = !s5_vld_reg || m_tready;
    assign s4_rdy  = !s4_vld_reg || s5_rdy;
    assign s3_rdy  = !s3_vld_reg || s4_rdy;
    assign mat_rdy = s3_rdy;

    // Stage three: every matrix entry times its vector component, kept at full width.
    always_comb
    begin
        prod_next[0] = mat.m0 * mat_vec.x;
        prod_next[1] = mat.m1 * mat_vec.y;
        prod_next[2] = mat.m2 * mat_vec.z;
        prod_next[3] = mat.m3 * mat_vec.x;
        prod_next[4] = mat.m4 * mat_vec.y;
        prod_next[5] = mat.m5 * mat_vec.z;
        prod_next[6] = mat.m6 * mat_vec.x;
        prod_next[7] = mat.m7 * mat_vec.y;
        prod_next[8] = mat.m8 * mat_vec.z;
    end

    // Stage four: the three row sums with the rounding half added.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = ACC_W'(prod_reg[3 * r]) + ACC_W'(prod_reg[3 * r + 1])
                        + ACC_W'(prod_reg[3 * r + 2]) + ROUND_HALF;
        end
    end

    // Stage five: drop the fraction bits and clip each component to the output range.
    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            shr[r] = acc_reg[r][ACC_W-1:FRAC_W];
            if (shr[r] > SAT_HI)
            begin
                res_next[r] = OUT_HI;
                sat_next    = 1'b1;
            end
            else if (shr[r] < SAT_LO)
            begin
                res_next[r] = OUT_LO;
                sat_next    = 1'b1;
            end
            else
            begin
                res_next[r] = shr[r][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            if (s3_rdy)
            begin
                s3_vld_reg <= mat_vld;
            end
            if (s4_rdy)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (s5_rdy)
            begin
                s5_vld_reg <= s4_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy && mat_vld)
        begin
            prod_reg <= prod_next;
        end
        if (s4_rdy && s3_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s5_rdy && s4_vld_reg)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tvalid = s5_vld_reg;
    assign m_tuser  = sat_reg;
    assign m_tdata  = M_TDATA_W'({res_reg[2], res_reg[1], res_reg[0]});

    // Count of words accepted but not yet delivered, kept for the checks below.
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready && !(m_tvalid && m_tready))
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (!(s_tvalid && s_tready) && m_tvalid && m_tready)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Every word in flight sits in exactly one stage: none lost, none duplicated.
    a_inflight_matches_stages: assert property (
        @(posedge clk) disable iff (!rst_n)
        32'(inflight_reg) == $countones({mat_stat.s1_vld, mat_stat.s2_vld,
                                         s3_vld_reg, s4_vld_reg, s5_vld_reg})
    ) else $error("in-flight count disagrees with stage valid bits");

    // A word flagged as clipped carries at least one component sitting on a bound.
    a_sat_on_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (res_reg[0] == OUT_HI || res_reg[0] == OUT_LO ||
             res_reg[1] == OUT_HI || res_reg[1] == OUT_LO ||
             res_reg[2] == OUT_HI || res_reg[2] == OUT_LO)
    ) else $error("saturation flag set with no component at a bound");

    // A full pipeline under a stalled output takes no new word.
    a_full_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (inflight_reg == 3'd5 && !m_tready) |-> !s_tready
    ) else $error("input accepted while every stage is held");

endmodule
